@@ design/twa_pkg.sv @@
// Package for the trimmed window average unit: widths, scale constant,
// opcodes and the sequencer state type. Depends on nothing.
`default_nettype none

package twa_pkg;

    localparam int SAMPLE_W      = 15;
    localparam int AVG_W         = 15;
    localparam int WHOLE_W       = 8;
    localparam int FRAC_W        = 8;
    localparam int DEFAULT_DEPTH = 10;

    localparam logic signed [SAMPLE_W-1:0] HUNDREDTHS_SCALE = 15'sd100;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_WAIT_DIV,
        ST_DONE
    } twa_state_t;

endpackage

`default_nettype wire

@@ design/twa_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
// Signed dividend, unsigned nonzero divisor. Depends on nothing.
`default_nettype none

module twa_divider #(
    parameter int DIVIDEND_W = 19,
    parameter int DIVISOR_W  = 4
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic signed [DIVIDEND_W-1:0] dividend,
    input  wire logic        [DIVISOR_W-1:0]  divisor,
    output logic                              done,
    output logic signed [DIVIDEND_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [DIVIDEND_W-1:0] num_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  den_reg;
    logic                  neg_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg  <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : dividend;
            neg_reg  <= dividend[DIVIDEND_W-1];
            den_reg  <= divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= STEP_W'(DIVIDEND_W);
        end else if (busy_reg) begin
            num_reg  <= {num_reg[DIVIDEND_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg  <= fits ? DIVISOR_W'(trial - {1'b0, den_reg}) : trial[DIVISOR_W-1:0];
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? DIVIDEND_W'(-quo_reg) : quo_reg;

endmodule

`default_nettype wire

@@ design/trimmed_window_average_unit.sv @@
// Top level of the trimmed window average unit: sample ring, scan sequencer, output register.
// Depends on twa_pkg and twa_divider.
//
// A push transaction (s_tuser = 0) stores whole*100 + frac in hundredths into a ring of the
// last WINDOW_DEPTH samples; it yields no result. A query transaction (s_tuser = 1) yields
// one result: the mean of the stored samples with the first largest one dropped, truncated
// toward zero, in hundredths on m_tdata, and m_tuser = 1 when any sample is stored. With one
// sample that sample is returned; with none the average is 0 and m_tuser = 0. A query reads
// the ring one entry per cycle through a single adder and comparator; with two or more
// samples it then starts the bit-serial divider and waits for the quotient, and at last
// loads the output register. s_tready stays low from a query until that load, which waits
// while an earlier result still waits on the master side. Pushes are taken while a result
// waits on the master side.
`default_nettype none

module trimmed_window_average_unit #(
    parameter int WINDOW_DEPTH = twa_pkg::DEFAULT_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // temp_whole [7:0], temp_frac [15:8]
    input  wire logic        s_tuser,   // opcode [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // average [14:0], zero [15]
    output logic             m_tuser    // valid_res [0]
);

    localparam int SW_  = twa_pkg::SAMPLE_W;
    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int SUMW = SW_ + CW;

    twa_pkg::twa_state_t state_reg, state_next;

    logic signed [SW_-1:0] mem [WINDOW_DEPTH];
    logic signed [SW_-1:0] rd_data_reg;

    logic [AW-1:0]         slot_reg;
    logic                  full_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         idx_reg;
    logic                  pipe_vld_reg;
    logic                  first_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [SW_-1:0] max_reg;
    logic [twa_pkg::AVG_W-1:0] avg_reg;
    logic                  res_valid_reg;
    logic                  m_tvalid_reg;
    logic [twa_pkg::AVG_W-1:0] m_avg_reg;
    logic                  m_flag_reg;

    logic                  s_hs;
    logic                  push_hs;
    logic                  query_hs;
    logic                  issue;
    logic                  scan_done;
    logic                  out_free;
    logic                  load_out;
    logic                  div_start;
    logic                  div_done;
    logic signed [SUMW-1:0] div_quo;
    logic signed [SUMW-1:0] trimmed;
    logic signed [SW_-1:0] sample;
    logic [CW-1:0]         query_cnt;

    assign s_tready  = (state_reg == twa_pkg::ST_IDLE);
    assign s_hs      = s_tvalid && s_tready;
    assign push_hs   = s_hs && (s_tuser == twa_pkg::OP_PUSH);
    assign query_hs  = s_hs && (s_tuser == twa_pkg::OP_QUERY);
    assign issue     = (state_reg == twa_pkg::ST_SCAN) && (idx_reg != cnt_reg);
    assign scan_done = (state_reg == twa_pkg::ST_SCAN) && !issue && !pipe_vld_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_out  = (state_reg == twa_pkg::ST_DONE) && out_free;
    assign div_start = (state_reg == twa_pkg::ST_DIV);
    assign trimmed   = sum_reg - SUMW'(max_reg);
    assign query_cnt = full_reg ? CW'(WINDOW_DEPTH) : CW'(slot_reg);

    assign sample = SW_'($signed(s_tdata[7:0])) * twa_pkg::HUNDREDTHS_SCALE
                  + $signed({7'b0, s_tdata[15:8]});

    twa_divider #(
        .DIVIDEND_W (SUMW),
        .DIVISOR_W  (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (trimmed),
        .divisor  (cnt_reg - CW'(1)),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= twa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            twa_pkg::ST_IDLE: begin
                if (query_hs) begin
                    state_next = (query_cnt == '0) ? twa_pkg::ST_DONE : twa_pkg::ST_SCAN;
                end
            end
            twa_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = (cnt_reg == CW'(1)) ? twa_pkg::ST_DONE : twa_pkg::ST_DIV;
                end
            end
            twa_pkg::ST_DIV: begin
                state_next = twa_pkg::ST_WAIT_DIV;
            end
            twa_pkg::ST_WAIT_DIV: begin
                if (div_done) begin
                    state_next = twa_pkg::ST_DONE;
                end
            end
            twa_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = twa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = twa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push_hs) begin
            mem[slot_reg] <= sample;
        end
        if (issue) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            full_reg     <= 1'b0;
            pipe_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pipe_vld_reg <= issue;
            if (push_hs) begin
                if (slot_reg == AW'(WINDOW_DEPTH - 1)) begin
                    slot_reg <= '0;
                    full_reg <= 1'b1;
                end else begin
                    slot_reg <= slot_reg + AW'(1);
                end
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (query_hs) begin
            cnt_reg       <= query_cnt;
            idx_reg       <= '0;
            first_reg     <= 1'b1;
            sum_reg       <= '0;
            avg_reg       <= '0;
            res_valid_reg <= (query_cnt != '0);
        end
        if (issue) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (pipe_vld_reg) begin
            sum_reg   <= sum_reg + SUMW'(rd_data_reg);
            first_reg <= 1'b0;
            if (first_reg || rd_data_reg > max_reg) begin
                max_reg <= rd_data_reg;
            end
        end
        if (scan_done && cnt_reg == CW'(1)) begin
            avg_reg <= sum_reg[twa_pkg::AVG_W-1:0];
        end
        if (div_done) begin
            avg_reg <= div_quo[twa_pkg::AVG_W-1:0];
        end
        if (load_out) begin
            m_avg_reg  <= avg_reg;
            m_flag_reg <= res_valid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_avg_reg};
    assign m_tuser  = m_flag_reg;

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0))
        else $error("empty-ring result carries a nonzero average");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, slot_reg} < (AW+1)'(WINDOW_DEPTH))
        else $error("write slot beyond ring depth");

    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        query_hs |=> !s_tready)
        else $error("input ready right after a query transaction");

    a_div_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == twa_pkg::ST_WAIT_DIV))
        else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
